/* hdl/stc_pkg.sv */
// stc_pkg: shared constants for the sparse transpose counting unit
// field widths, stream packing, register indexes and parameter defaults
// no dependencies
`default_nettype none

package stc_pkg;

   localparam int TERM_CAPACITY_DEFAULT = 32;
   localparam int DIM_LIMIT_DEFAULT     = 32;

   localparam int IDX_W   = 5;
   localparam int VALUE_W = 32;
   localparam int TERM_W  = 2 * IDX_W + VALUE_W;
   localparam int DATA_W  = ((TERM_W + 7) / 8) * 8;
   localparam int DIM_W   = 6;
   localparam int MAX_DIM = 1 << IDX_W;

   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS = 4'd1;

   localparam logic [DIM_W-1:0] NUM_ROWS_RESET = 6'd32;
   localparam logic [DIM_W-1:0] NUM_COLS_RESET = 6'd32;

   localparam int RSP_USER_W = 2;

endpackage

`default_nettype wire

/* hdl/stc_ram.sv */
// stc_ram: generic single write port, single read port memory
// read data is registered; no dependencies
`default_nettype none

module stc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* hdl/sparse_transpose_counting_unit.sv */
// sparse_transpose_counting_unit: fast transpose of a sparse matrix by column counting
// depends on stc_pkg and stc_ram
//
// usage:
//   req_ carries one source term per transaction (tuser = element present, tlast = last
//   item of the matrix). rsp_ returns the transposed terms in order of source column,
//   stable within a column; tlast marks the final one. an empty matrix gives one result
//   with tuser[0] low. csr_ writes num_rows (index 0) and num_cols (index 1); the user
//   must write them only while the block is idle; the block does not enforce this.
// timing:
//   loading reads the column count of each kept term, then writes it back.
//   after the last item: prefix pass over the count memory, then scatter of
//   each term (term read, start read, write), then emit of each term through
//   the output memory read port. req_tready is low from the last item until
//   the final result is registered.
// reset: counts, term count and drop flag cleared, registers at 32, no idle pass.
// stall: emission waits on rsp_tready; the final result register may still
//   wait while loading of the next matrix goes on.
`default_nettype none

module sparse_transpose_counting_unit #(
   parameter int TERM_CAPACITY = stc_pkg::TERM_CAPACITY_DEFAULT,
   parameter int DIM_LIMIT     = stc_pkg::DIM_LIMIT_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // row [4:0], col [9:5], value [41:10], zero fill
   input  wire logic [stc_pkg::DATA_W-1:0]       req_tdata,
   // element_present
   input  wire logic                             req_tuser,
   input  wire logic                             req_tlast,

   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // out_row [4:0], out_col [9:5], out_value [41:10], zero fill
   output logic [stc_pkg::DATA_W-1:0]            rsp_tdata,
   // out_present [0], terms_dropped [1]
   output logic [stc_pkg::RSP_USER_W-1:0]        rsp_tuser,
   output logic                                  rsp_tlast,

   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [stc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [stc_pkg::DIM_W-1:0]        csr_wdata
);

   localparam int IW  = stc_pkg::IDX_W;
   localparam int TW  = stc_pkg::TERM_W;
   localparam int CW  = $clog2(TERM_CAPACITY + 1);
   localparam int TAW = (TERM_CAPACITY > 1) ? $clog2(TERM_CAPACITY) : 1;
   localparam int COL_DEPTH = (DIM_LIMIT < stc_pkg::MAX_DIM) ? DIM_LIMIT : stc_pkg::MAX_DIM;
   localparam int CAW = (COL_DEPTH > 1) ? $clog2(COL_DEPTH) : 1;
   localparam logic [CW-1:0]  CAP    = CW'(TERM_CAPACITY);
   localparam logic [CAW:0]   PDEPTH = (CAW + 1)'(COL_DEPTH);
   localparam logic [8:0]     DLIM   = 9'(DIM_LIMIT);

   localparam logic [3:0] S_LOAD   = 4'd0;
   localparam logic [3:0] S_INC    = 4'd1;
   localparam logic [3:0] S_PRE    = 4'd2;
   localparam logic [3:0] S_SC_RD  = 4'd3;
   localparam logic [3:0] S_SC_COL = 4'd4;
   localparam logic [3:0] S_SC_WR  = 4'd5;
   localparam logic [3:0] S_EM_RD  = 4'd6;
   localparam logic [3:0] S_EM_LD  = 4'd7;
   localparam logic [3:0] S_EMPTY  = 4'd8;

   logic [3:0]             state_ff, state_in;
   logic [stc_pkg::DIM_W-1:0] num_rows_ff, num_rows_in, num_cols_ff, num_cols_in;
   logic [CW-1:0]          stored_ff, stored_in;
   logic                   drop_ff, drop_in;
   logic                   last_ff, last_in;
   logic [COL_DEPTH-1:0]   cnt_vld_ff, cnt_vld_in;
   logic [CAW-1:0]         cnt_rd_addr_ff, cnt_rd_addr_in;
   logic [CAW:0]           pidx_ff, pidx_in;
   logic                   pvld_ff, pvld_in;
   logic [CW-1:0]          sum_ff, sum_in;
   logic [CW-1:0]          tidx_ff, tidx_in;
   logic [TW-1:0]          term_ff, term_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   logic [TW-1:0]          rsp_data_ff, rsp_data_in;
   logic [stc_pkg::RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   term_wr_en, term_rd_en;
   logic [TAW-1:0]         term_wr_addr, term_rd_addr;
   logic [TW-1:0]          term_rd_data;
   logic                   cnt_wr_en, cnt_rd_en;
   logic [CAW-1:0]         cnt_wr_addr;
   logic [CW-1:0]          cnt_wr_data, cnt_rd_data, cnt_q;
   logic                   out_wr_en, out_rd_en;
   logic [TAW-1:0]         out_wr_addr, out_rd_addr;
   logic [TW-1:0]          out_wr_data, out_rd_data;

   logic                   req_fire, rsp_fire, rsp_free;
   logic [IW-1:0]          in_row, in_col;
   logic                   in_range, keep;
   logic [CW-1:0]          tidx_nxt;

   assign req_fire  = req_tvalid & req_tready;
   assign rsp_fire  = rsp_vld_ff & rsp_tready;
   assign rsp_free  = ~rsp_vld_ff | rsp_tready;
   assign csr_ready = 1'b1;

   assign in_row   = req_tdata[IW-1:0];
   assign in_col   = req_tdata[2*IW-1:IW];
   assign in_range = ({1'b0, in_row} < num_rows_ff) && ({1'b0, in_col} < num_cols_ff) &&
                     ({4'b0, in_row} < DLIM) && ({4'b0, in_col} < DLIM);
   assign keep     = req_tuser & in_range & (stored_ff < CAP);
   assign cnt_q    = cnt_vld_ff[cnt_rd_addr_ff] ? cnt_rd_data : '0;
   assign tidx_nxt = tidx_ff + CW'(1);

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(stc_pkg::DATA_W - TW){1'b0}}, rsp_data_ff};
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      num_rows_in = num_rows_ff;
      num_cols_in = num_cols_ff;
      if (csr_valid) begin
         if (csr_index == stc_pkg::CSR_NUM_ROWS) begin
            num_rows_in = csr_wdata;
         end else if (csr_index == stc_pkg::CSR_NUM_COLS) begin
            num_cols_in = csr_wdata;
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      stored_in      = stored_ff;
      drop_in        = drop_ff;
      last_in        = last_ff;
      cnt_vld_in     = cnt_vld_ff;
      cnt_rd_addr_in = cnt_rd_addr_ff;
      pidx_in        = pidx_ff;
      pvld_in        = pvld_ff;
      sum_in         = sum_ff;
      tidx_in        = tidx_ff;
      term_in        = term_ff;
      rsp_vld_in     = rsp_fire ? 1'b0 : rsp_vld_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;
      rsp_last_in    = rsp_last_ff;
      req_tready     = 1'b0;
      term_wr_en     = 1'b0;
      term_wr_addr   = stored_ff[TAW-1:0];
      term_rd_en     = 1'b0;
      term_rd_addr   = tidx_ff[TAW-1:0];
      cnt_wr_en      = 1'b0;
      cnt_wr_addr    = cnt_rd_addr_ff;
      cnt_wr_data    = cnt_q + CW'(1);
      cnt_rd_en      = 1'b0;
      out_wr_en      = 1'b0;
      out_wr_addr    = cnt_q[TAW-1:0];
      out_wr_data    = {term_ff[TW-1:2*IW], term_ff[IW-1:0], term_ff[2*IW-1:IW]};
      out_rd_en      = 1'b0;
      out_rd_addr    = tidx_ff[TAW-1:0];

      case (state_ff)
         S_LOAD: begin
            req_tready = 1'b1;
            if (req_fire) begin
               last_in = req_tlast;
               if (req_tuser & ~keep) begin
                  drop_in = 1'b1;
               end
               if (keep) begin
                  term_wr_en     = 1'b1;
                  cnt_rd_en      = 1'b1;
                  cnt_rd_addr_in = in_col[CAW-1:0];
                  stored_in      = stored_ff + CW'(1);
                  state_in       = S_INC;
               end else if (req_tlast) begin
                  pidx_in  = '0;
                  pvld_in  = 1'b0;
                  sum_in   = '0;
                  state_in = (stored_ff == '0) ? S_EMPTY : S_PRE;
               end
            end
         end
         S_INC: begin
            cnt_wr_en                  = 1'b1;
            cnt_vld_in[cnt_rd_addr_ff] = 1'b1;
            if (last_ff) begin
               pidx_in  = '0;
               pvld_in  = 1'b0;
               sum_in   = '0;
               state_in = S_PRE;
            end else begin
               state_in = S_LOAD;
            end
         end
         S_PRE: begin
            pvld_in = pidx_ff < PDEPTH;
            if (pidx_ff < PDEPTH) begin
               cnt_rd_en      = 1'b1;
               cnt_rd_addr_in = pidx_ff[CAW-1:0];
               pidx_in        = pidx_ff + (CAW + 1)'(1);
            end
            if (pvld_ff) begin
               cnt_wr_en                  = 1'b1;
               cnt_wr_data                = sum_ff;
               cnt_vld_in[cnt_rd_addr_ff] = 1'b1;
               sum_in                     = sum_ff + cnt_q;
               if (pidx_ff == PDEPTH) begin
                  tidx_in  = '0;
                  state_in = S_SC_RD;
               end
            end
         end
         S_SC_RD: begin
            term_rd_en = 1'b1;
            state_in   = S_SC_COL;
         end
         S_SC_COL: begin
            term_in        = term_rd_data;
            cnt_rd_en      = 1'b1;
            cnt_rd_addr_in = term_rd_data[IW+CAW-1:IW];
            state_in       = S_SC_WR;
         end
         S_SC_WR: begin
            out_wr_en = 1'b1;
            cnt_wr_en = 1'b1;
            if (tidx_nxt == stored_ff) begin
               tidx_in  = '0;
               state_in = S_EM_RD;
            end else begin
               tidx_in  = tidx_nxt;
               state_in = S_SC_RD;
            end
         end
         S_EM_RD: begin
            if (rsp_free) begin
               out_rd_en = 1'b1;
               state_in  = S_EM_LD;
            end
         end
         S_EM_LD: begin
            rsp_vld_in  = 1'b1;
            rsp_data_in = out_rd_data;
            rsp_user_in = {drop_ff, 1'b1};
            rsp_last_in = tidx_nxt == stored_ff;
            tidx_in     = tidx_nxt;
            if (tidx_nxt == stored_ff) begin
               stored_in  = '0;
               drop_in    = 1'b0;
               cnt_vld_in = '0;
               state_in   = S_LOAD;
            end else begin
               state_in = S_EM_RD;
            end
         end
         S_EMPTY: begin
            if (rsp_free) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = '0;
               rsp_user_in = {drop_ff, 1'b0};
               rsp_last_in = 1'b1;
               stored_in   = '0;
               drop_in     = 1'b0;
               cnt_vld_in  = '0;
               state_in    = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         num_rows_ff <= stc_pkg::NUM_ROWS_RESET;
         num_cols_ff <= stc_pkg::NUM_COLS_RESET;
         stored_ff   <= '0;
         drop_ff     <= 1'b0;
         last_ff     <= 1'b0;
         cnt_vld_ff  <= '0;
         pidx_ff     <= '0;
         pvld_ff     <= 1'b0;
         tidx_ff     <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         num_rows_ff <= num_rows_in;
         num_cols_ff <= num_cols_in;
         stored_ff   <= stored_in;
         drop_ff     <= drop_in;
         last_ff     <= last_in;
         cnt_vld_ff  <= cnt_vld_in;
         pidx_ff     <= pidx_in;
         pvld_ff     <= pvld_in;
         tidx_ff     <= tidx_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_rd_addr_ff <= cnt_rd_addr_in;
      sum_ff         <= sum_in;
      term_ff        <= term_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_user_ff    <= rsp_user_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // loaded terms: row [4:0], col [9:5], value above
   stc_ram #(
      .WIDTH (TW),
      .DEPTH (TERM_CAPACITY)
   ) u_term_ram (
      .clock   (clock),
      .wr_en   (term_wr_en),
      .wr_addr (term_wr_addr),
      .wr_data (req_tdata[TW-1:0]),
      .rd_en   (term_rd_en),
      .rd_addr (term_rd_addr),
      .rd_data (term_rd_data)
   );

   // column counts, overwritten by start positions in the prefix pass
   stc_ram #(
      .WIDTH (CW),
      .DEPTH (COL_DEPTH)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr_in),
      .rd_data (cnt_rd_data)
   );

   // transposed terms in output order
   stc_ram #(
      .WIDTH (TW),
      .DEPTH (TERM_CAPACITY)
   ) u_out_ram (
      .clock   (clock),
      .wr_en   (out_wr_en),
      .wr_addr (out_wr_addr),
      .wr_data (out_wr_data),
      .rd_en   (out_rd_en),
      .rd_addr (out_rd_addr),
      .rd_data (out_rd_data)
   );

endmodule

`default_nettype wire
